// ----- hdl/vrt_pkg.sv -----
// Package for the voxel ray traversal block: widths, result and face codes,
// sequencer state type. No dependencies.
`default_nettype none
package vrt_pkg;

   // default fixed-point formats
   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int DIR_FRAC_BITS_DEF   = 14;
   localparam int T_FRAC_BITS_DEF     = 16;

   // crossing values are 48 bit unsigned, all ones means never
   localparam int CROSS_W = 48;
   localparam logic [CROSS_W-1:0] CROSS_MAX = {CROSS_W{1'b1}};

   // divider: dividend and quotient width, divisor width
   localparam int NUM_W  = 64;
   localparam int DEN_W  = 25;
   localparam int ROOT_W = 17;
   localparam int SUMSQ_W = 32;

   // command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_REPLY = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_QUERY  = 2'd0,
      STATUS_HIT    = 2'd1,
      STATUS_MISS   = 2'd2,
      STATUS_REJECT = 2'd3
   } status_type;

   // entry face codes
   typedef enum logic [2:0] {
      FACE_NONE  = 3'd0,
      FACE_LEFT  = 3'd1,
      FACE_RIGHT = 3'd2,
      FACE_UP    = 3'd3,
      FACE_DOWN  = 3'd4,
      FACE_BACK  = 3'd5,
      FACE_FRONT = 3'd6
   } face_type;

   // sequencer states
   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SQUARE  = 7'b0000010,
      ST_ROOT    = 7'b0000100,
      ST_LOAD    = 7'b0001000,
      ST_DIVIDE  = 7'b0010000,
      ST_PICK    = 7'b0100000,
      ST_ADVANCE = 7'b1000000
   } state_type;

endpackage
`default_nettype wire

// ----- hdl/vrt_chan_if.sv -----
// Channel interfaces for the voxel ray traversal block: request and response
// words with valid/ready. No dependencies.
`default_nettype none
interface vrt_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic [15:0]        max_distance;
   logic               voxel_loaded;
   logic               voxel_solid;

   modport source (output valid, command, origin_x, origin_y, origin_z, dir_x, dir_y,
                   dir_z, max_distance, voxel_loaded, voxel_solid, input ready);
   modport sink (input valid, command, origin_x, origin_y, origin_z, dir_x, dir_y,
                 dir_z, max_distance, voxel_loaded, voxel_solid, output ready);
endinterface

interface vrt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] voxel_x;
   logic signed [31:0] voxel_y;
   logic signed [31:0] voxel_z;
   logic [2:0]         entry_face;

   modport source (output valid, status, voxel_x, voxel_y, voxel_z, entry_face,
                   input ready);
   modport sink (input valid, status, voxel_x, voxel_y, voxel_z, entry_face,
                 output ready);
endinterface
`default_nettype wire

// ----- hdl/voxel_ray_traversal.sv -----
// Top level of the voxel ray traversal block: sequencer, shared divider,
// square root and stepping logic. Depends on vrt_pkg and vrt_chan_if.
//
// Use: req_ch carries words; command start gives a ray (origin, direction,
// distance limit), command reply answers the last voxel query. rsp_ch gives
// one word per request word: a voxel query, a hit, a miss or a rejection of
// a near-zero direction.
// A start works through three squares, 16 square root steps and up to seven
// divisions (an axis with zero direction skips its two), one quotient bit per
// cycle in the shared restoring divider, before the origin query appears.
// A reply that hits, finds its voxel unloaded or arrives with no ray is answered
// at acceptance; a reply that steps or misses past the limit goes through
// accept, axis pick, then compare and step before its answer.
// One request word is worked on at a time: req_ch.ready is high only while
// the sequencer is idle and the response register is empty, so a stalled
// receiver holds the block until the response word is taken.
// Reset (synchronous, active high) clears the sequencer, the response valid,
// the ray's active flag and its entry face, so a reply after reset gives a miss.
`default_nettype none
module voxel_ray_traversal #(
   parameter int COORD_FRAC_BITS = vrt_pkg::COORD_FRAC_BITS_DEF,
   parameter int DIR_FRAC_BITS   = vrt_pkg::DIR_FRAC_BITS_DEF,
   parameter int T_FRAC_BITS     = vrt_pkg::T_FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   vrt_req_if.sink   req_ch,
   vrt_rsp_if.source rsp_ch
);

   localparam int CW       = vrt_pkg::CROSS_W;
   localparam int NW       = vrt_pkg::NUM_W;
   localparam int DW       = vrt_pkg::DEN_W;
   localparam int RW       = vrt_pkg::ROOT_W;
   localparam int SW       = vrt_pkg::SUMSQ_W;
   localparam int DIST_W   = COORD_FRAC_BITS + 1;
   localparam int SH       = T_FRAC_BITS + DIR_FRAC_BITS - COORD_FRAC_BITS;
   localparam int SH_NUM   = (SH > 0) ? SH : 0;
   localparam int SH_DEN   = (SH < 0) ? -SH : 0;
   localparam int SH_RAD   = T_FRAC_BITS + DIR_FRAC_BITS;
   localparam int NEAR_MIN = ((1 << DIR_FRAC_BITS) + 999) / 1000;
   localparam logic [DIST_W-1:0] ONE = DIST_W'(1) << COORD_FRAC_BITS;

   // sequencer and ray state
   vrt_pkg::state_type state_ff, state_in;
   logic               active_ff, active_in;
   logic [31:0]        voxel_ff [3];
   logic [31:0]        voxel_in [3];
   logic [CW-1:0]      cross_ff [3];
   logic [CW-1:0]      cross_in [3];
   logic [CW-1:0]      incr_ff [3];
   logic [CW-1:0]      incr_in [3];
   logic [1:0]         sign_ff [3];
   logic [1:0]         sign_in [3];
   logic [CW-1:0]      radius_ff, radius_in;
   vrt_pkg::face_type  face_ff, face_in;

   // setup operands
   logic [15:0]        absd_ff [3];
   logic [15:0]        absd_in [3];
   logic [DIST_W-1:0]  dist_ff [3];
   logic [DIST_W-1:0]  dist_in [3];
   logic [15:0]        maxd_ff, maxd_in;
   logic [SW-1:0]      sumsq_ff, sumsq_in;
   logic [1:0]         idx_ff, idx_in;
   logic [2:0]         job_ff, job_in;
   logic [1:0]         axis_ff, axis_in;

   // square root unit
   logic [SW-1:0]      sq_v_ff, sq_v_in;
   logic [SW-1:0]      sq_r_ff, sq_r_in;
   logic [SW-1:0]      sq_bit_ff, sq_bit_in;
   logic [RW-1:0]      root_ff, root_in;

   // divider unit
   logic [NW-1:0]      div_num_ff, div_num_in;
   logic [NW-1:0]      div_q_ff, div_q_in;
   logic [DW-1:0]      div_rem_ff, div_rem_in;
   logic [DW-1:0]      div_den_ff, div_den_in;
   logic [5:0]         div_cnt_ff, div_cnt_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   vrt_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [31:0]        rsp_x_ff, rsp_x_in;
   logic [31:0]        rsp_y_ff, rsp_y_in;
   logic [31:0]        rsp_z_ff, rsp_z_in;
   vrt_pkg::face_type  rsp_face_ff, rsp_face_in;

   // combinational helpers
   logic               req_fire;
   logic [15:0]        req_abs [3];
   logic signed [15:0] req_dir [3];
   logic signed [31:0] req_org [3];
   logic               req_near;
   logic [31:0]        sq_prod;
   logic [SW:0]        sq_trial;
   logic               sq_ge;
   logic [SW-1:0]      sq_r_nx;
   logic [DW:0]        div_rem_sh;
   logic               div_ge;
   logic [NW-1:0]      div_q_nx;
   logic [CW-1:0]      div_quo;
   logic [1:0]         job_axis;
   logic [DIST_W-1:0]  job_base;
   logic [CW:0]        step_sum;
   logic [CW-1:0]      pick_cross;

   assign req_dir[0] = req_ch.dir_x;
   assign req_dir[1] = req_ch.dir_y;
   assign req_dir[2] = req_ch.dir_z;
   assign req_org[0] = req_ch.origin_x;
   assign req_org[1] = req_ch.origin_y;
   assign req_org[2] = req_ch.origin_z;

   assign req_ch.ready = (state_ff == vrt_pkg::ST_IDLE) && !rsp_valid_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.voxel_x    = rsp_x_ff;
   assign rsp_ch.voxel_y    = rsp_y_ff;
   assign rsp_ch.voxel_z    = rsp_z_ff;
   assign rsp_ch.entry_face = rsp_face_ff;

   // magnitudes and near-zero test of the incoming direction
   always_comb begin
      req_near = 1'b1;
      for (int a = 0; a < 3; a++) begin
         req_abs[a] = req_dir[a][15] ? 16'(-req_dir[a]) : 16'(req_dir[a]);
         if (req_abs[a] >= 16'(NEAR_MIN)) begin
            req_near = 1'b0;
         end
      end
   end

   // square of one magnitude per cycle
   assign sq_prod = 32'(absd_ff[idx_ff]) * 32'(absd_ff[idx_ff]);

   // square root step
   assign sq_trial = {1'b0, sq_r_ff} + {1'b0, sq_bit_ff};
   assign sq_ge    = {1'b0, sq_v_ff} >= sq_trial;
   assign sq_r_nx  = sq_ge ? (sq_r_ff >> 1) + sq_bit_ff : sq_r_ff >> 1;

   // restoring divider step, one quotient bit per cycle
   assign div_rem_sh = {div_rem_ff, div_num_ff[NW-1]};
   assign div_ge     = div_rem_sh >= {1'b0, div_den_ff};
   assign div_q_nx   = {div_q_ff[NW-2:0], div_ge};
   assign div_quo    = ((div_den_ff == '0) || (|div_q_nx[NW-1:CW])) ? vrt_pkg::CROSS_MAX
                       : div_q_nx[CW-1:0];

   // operand of the current division job
   assign job_axis = job_ff[2:1];
   assign job_base = job_ff[0] ? ONE : dist_ff[job_axis];

   // stepping along the picked axis
   assign pick_cross = cross_ff[axis_ff];
   assign step_sum   = {1'b0, pick_cross} + {1'b0, incr_ff[axis_ff]};

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      voxel_in  = voxel_ff;
      cross_in  = cross_ff;
      incr_in   = incr_ff;
      sign_in   = sign_ff;
      radius_in = radius_ff;
      face_in   = face_ff;
      absd_in   = absd_ff;
      dist_in   = dist_ff;
      maxd_in   = maxd_ff;
      sumsq_in  = sumsq_ff;
      idx_in    = idx_ff;
      job_in    = job_ff;
      axis_in   = axis_ff;
      sq_v_in   = sq_v_ff;
      sq_r_in   = sq_r_ff;
      sq_bit_in = sq_bit_ff;
      root_in   = root_ff;
      div_num_in = div_num_ff;
      div_q_in   = div_q_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_face_in   = rsp_face_ff;

      unique case (state_ff)
         vrt_pkg::ST_IDLE: begin
            if (req_fire) begin
               rsp_x_in    = '0;
               rsp_y_in    = '0;
               rsp_z_in    = '0;
               rsp_face_in = vrt_pkg::FACE_NONE;
               if (req_ch.command == vrt_pkg::CMD_START) begin
                  face_in = vrt_pkg::FACE_NONE;
                  if (req_near) begin
                     // near-zero direction, rejected at once
                     active_in     = 1'b0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = vrt_pkg::STATUS_REJECT;
                  end else begin
                     // latch origin voxel, signs and first distances
                     for (int a = 0; a < 3; a++) begin
                        voxel_in[a] = 32'(req_org[a] >>> COORD_FRAC_BITS);
                        absd_in[a]  = req_abs[a];
                        if (req_dir[a] == 16'sd0) begin
                           sign_in[a] = 2'b00;
                        end else if (req_dir[a][15]) begin
                           sign_in[a] = 2'b11;
                        end else begin
                           sign_in[a] = 2'b01;
                        end
                        if (req_dir[a][15]) begin
                           dist_in[a] = DIST_W'(req_org[a][COORD_FRAC_BITS-1:0]);
                        end else if (req_org[a][COORD_FRAC_BITS-1:0] != '0) begin
                           dist_in[a] = ONE - DIST_W'(req_org[a][COORD_FRAC_BITS-1:0]);
                        end else if (req_org[a] == 32'sd0) begin
                           dist_in[a] = ONE;
                        end else begin
                           dist_in[a] = '0;
                        end
                     end
                     maxd_in  = req_ch.max_distance;
                     sumsq_in = '0;
                     idx_in   = 2'd0;
                     state_in = vrt_pkg::ST_SQUARE;
                  end
               end else if (!active_ff || !req_ch.voxel_loaded) begin
                  // no ray, or voxel not loaded
                  active_in     = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = vrt_pkg::STATUS_MISS;
               end else if (req_ch.voxel_solid) begin
                  active_in     = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = vrt_pkg::STATUS_HIT;
                  rsp_x_in      = voxel_ff[0];
                  rsp_y_in      = voxel_ff[1];
                  rsp_z_in      = voxel_ff[2];
                  rsp_face_in   = face_ff;
               end else begin
                  state_in = vrt_pkg::ST_PICK;
               end
            end
         end

         vrt_pkg::ST_SQUARE: begin
            // sum of squared magnitudes
            sumsq_in = sumsq_ff + sq_prod;
            idx_in   = idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               sq_v_in   = sumsq_ff + sq_prod;
               sq_r_in   = '0;
               sq_bit_in = SW'(1) << (SW - 2);
               state_in  = vrt_pkg::ST_ROOT;
            end
         end

         vrt_pkg::ST_ROOT: begin
            // one result bit per cycle
            if (sq_ge) begin
               sq_v_in = SW'(sq_trial - {1'b0, sq_v_ff} == '0 ? '0 : {1'b0, sq_v_ff} - sq_trial);
            end
            sq_r_in   = sq_r_nx;
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               root_in  = RW'(sq_r_nx);
               job_in   = 3'd0;
               state_in = vrt_pkg::ST_LOAD;
            end
         end

         vrt_pkg::ST_LOAD: begin
            // set up the next division, or skip a non-moving axis
            div_rem_in = '0;
            div_q_in   = '0;
            div_cnt_in = '0;
            if (job_ff == 3'd6) begin
               div_num_in = NW'(maxd_ff) << SH_RAD;
               div_den_in = DW'(root_ff);
               state_in   = vrt_pkg::ST_DIVIDE;
            end else if (sign_ff[job_axis] == 2'b00) begin
               cross_in[job_axis] = vrt_pkg::CROSS_MAX;
               incr_in[job_axis]  = vrt_pkg::CROSS_MAX;
               job_in             = job_ff + 3'd2;
            end else begin
               div_num_in = NW'(job_base) << SH_NUM;
               div_den_in = DW'(absd_ff[job_axis]) << SH_DEN;
               state_in   = vrt_pkg::ST_DIVIDE;
            end
         end

         vrt_pkg::ST_DIVIDE: begin
            div_rem_in = div_ge ? DW'(div_rem_sh - {1'b0, div_den_ff}) : DW'(div_rem_sh);
            div_num_in = div_num_ff << 1;
            div_q_in   = div_q_nx;
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'(NW - 1)) begin
               job_in = job_ff + 3'd1;
               if (job_ff == 3'd6) begin
                  // setup done, ask for the origin voxel
                  radius_in     = div_quo;
                  active_in     = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = vrt_pkg::STATUS_QUERY;
                  rsp_x_in      = voxel_ff[0];
                  rsp_y_in      = voxel_ff[1];
                  rsp_z_in      = voxel_ff[2];
                  rsp_face_in   = vrt_pkg::FACE_NONE;
                  state_in      = vrt_pkg::ST_IDLE;
               end else begin
                  if (job_ff[0]) begin
                     incr_in[job_axis] = div_quo;
                  end else begin
                     cross_in[job_axis] = div_quo;
                  end
                  state_in = vrt_pkg::ST_LOAD;
               end
            end
         end

         vrt_pkg::ST_PICK: begin
            // least crossing, ties to the later axis
            if (cross_ff[0] < cross_ff[1]) begin
               axis_in = (cross_ff[0] < cross_ff[2]) ? 2'd0 : 2'd2;
            end else begin
               axis_in = (cross_ff[1] < cross_ff[2]) ? 2'd1 : 2'd2;
            end
            state_in = vrt_pkg::ST_ADVANCE;
         end

         vrt_pkg::ST_ADVANCE: begin
            rsp_valid_in = 1'b1;
            state_in     = vrt_pkg::ST_IDLE;
            if ((pick_cross == vrt_pkg::CROSS_MAX) || (pick_cross > radius_ff)) begin
               active_in     = 1'b0;
               rsp_status_in = vrt_pkg::STATUS_MISS;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               rsp_z_in      = '0;
               rsp_face_in   = vrt_pkg::FACE_NONE;
            end else begin
               voxel_in[axis_ff] = sign_ff[axis_ff][1] ? voxel_ff[axis_ff] - 32'd1
                                   : voxel_ff[axis_ff] + 32'd1;
               cross_in[axis_ff] = step_sum[CW] ? vrt_pkg::CROSS_MAX : step_sum[CW-1:0];
               unique case ({axis_ff, sign_ff[axis_ff][1]})
                  3'b000:  face_in = vrt_pkg::FACE_LEFT;
                  3'b001:  face_in = vrt_pkg::FACE_RIGHT;
                  3'b010:  face_in = vrt_pkg::FACE_UP;
                  3'b011:  face_in = vrt_pkg::FACE_DOWN;
                  3'b100:  face_in = vrt_pkg::FACE_BACK;
                  default: face_in = vrt_pkg::FACE_FRONT;
               endcase
               rsp_status_in = vrt_pkg::STATUS_QUERY;
               rsp_x_in      = voxel_in[0];
               rsp_y_in      = voxel_in[1];
               rsp_z_in      = voxel_in[2];
               rsp_face_in   = face_in;
            end
         end

         default: begin
            state_in = vrt_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vrt_pkg::ST_IDLE;
         active_ff    <= 1'b0;
         face_ff      <= vrt_pkg::FACE_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         face_ff      <= face_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      voxel_ff   <= voxel_in;
      cross_ff   <= cross_in;
      incr_ff    <= incr_in;
      sign_ff    <= sign_in;
      radius_ff  <= radius_in;
      absd_ff    <= absd_in;
      dist_ff    <= dist_in;
      maxd_ff    <= maxd_in;
      sumsq_ff   <= sumsq_in;
      idx_ff     <= idx_in;
      job_ff     <= job_in;
      axis_ff    <= axis_in;
      sq_v_ff    <= sq_v_in;
      sq_r_ff    <= sq_r_in;
      sq_bit_ff  <= sq_bit_in;
      root_ff    <= root_in;
      div_num_ff <= div_num_in;
      div_q_ff   <= div_q_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      div_cnt_ff <= div_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_z_ff      <= rsp_z_in;
      rsp_face_ff   <= rsp_face_in;
   end

endmodule
`default_nettype wire
